FILE: design/spf_pkg.sv
package spf_pkg;

  // Table geometry.
  parameter int TABLE_DEPTH = 65536;
  parameter int IDX_W       = $clog2(TABLE_DEPTH);

  // Field widths.
  parameter int VALUE_W  = 16;
  parameter int PRIME_W  = 16;
  parameter int EXP_W    = 5;
  parameter int STATUS_W = 3;

  // A 16-bit value has at most six distinct prime factors.
  parameter int MAX_PRIMES = 6;
  parameter int K_W        = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_FACTOR   = 3'd0,
    ST_BUILT    = 3'd1,
    ST_NOFACT   = 3'd2,
    ST_RANGE    = 3'd3,
    ST_NOTBUILT = 3'd4
  } status_e;

  typedef enum logic {
    OP_BUILD  = 1'b0,
    OP_FACTOR = 1'b1
  } opcode_e;

  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_CLEAR,
    SQ_SRD,
    SQ_SCHK,
    SQ_MRD,
    SQ_MCHK,
    SQ_FRD,
    SQ_FCHK,
    SQ_FDIV,
    SQ_FEMIT,
    SQ_RESP
  } seq_state_e;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [PRIME_W-1:0] wr_data;
  } ram_req_t;

  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] num;
    logic [VALUE_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] quot;
    logic [VALUE_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic               valid;
    status_e            status;
    logic [PRIME_W-1:0] prime;
    logic [EXP_W-1:0]   exponent;
    logic               last;
  } res_t;

endpackage

FILE: design/spf_sieve_factorizer_unit.sv
// Smallest-prime-factor sieve and factorizer. An item with opcode 0 clears the
// factor table up to the limit held in the configuration register and sieves
// it, then returns one "build done" item. The build runs a clearing sweep and
// then the sieve, which visits each table entry once in the outer scan and
// once for every prime up to the square root that strikes it; each visit
// makes a read of the table memory and, if the entry is still untouched, a
// write. An item with opcode 1 returns one item per distinct prime factor in
// ascending order with its exponent, and the final one is marked last. Each
// prime takes a table read, exponent + 1 trial divisions by that prime (done
// by a bit-serial divider) and the handover of the result to the output.
// Queries made before a build, with a value below two, or above the limit of
// the last build return a single status item. Writing the limit register
// marks the table as not built; write it only while the block is idle. A new
// item is taken whenever the sequencer is idle, even if the last result still
// waits in the output register.
module spf_sieve_factorizer_unit
  import spf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                opcode_i,
  input  logic [VALUE_W-1:0]  value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [PRIME_W-1:0]  prime_o,
  output logic [EXP_W-1:0]    exponent_o,
  output logic                last_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [VALUE_W-1:0]  cfg_data_i
);

  logic [VALUE_W-1:0]  limit_q;
  logic [IDX_W-1:0]    eff_lim;
  logic                cfg_we;
  logic                out_ready;
  res_t                res;
  ram_req_t            ram_req;
  logic [PRIME_W-1:0]  ram_rdata;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] status_q;
  logic [PRIME_W-1:0]  prime_q;
  logic [EXP_W-1:0]    exp_q;
  logic                last_q;

  // The limit register is always writable.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= {VALUE_W{1'b1}};
    end else if (cfg_we) begin
      limit_q <= cfg_data_i;
    end
  end

  // The limit is clipped to the last entry of the table.
  always_comb begin
    if (32'(limit_q) > 32'(TABLE_DEPTH - 1)) begin
      eff_lim = IDX_W'(TABLE_DEPTH - 1);
    end else begin
      eff_lim = IDX_W'(limit_q);
    end
  end

  // Single output register: it loads when empty or when its item is taken.
  assign out_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.valid) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      status_q <= res.status;
      prime_q  <= res.prime;
      exp_q    <= res.exponent;
      last_q   <= res.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign prime_o     = prime_q;
  assign exponent_o  = exp_q;
  assign last_o      = last_q;

  spf_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  spf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  spf_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .value_i     (value_i),
    .cfg_we_i    (cfg_we),
    .eff_lim_i   (eff_lim),
    .out_ready_i (out_ready),
    .res_o       (res),
    .ram_o       (ram_req),
    .ram_rdata_i (ram_rdata),
    .div_o       (div_req),
    .div_i       (div_rsp)
  );

endmodule

FILE: design/spf_ram.sv
module spf_ram
  import spf_pkg::*;
(
  input  logic               clk_i,
  input  ram_req_t           req_i,
  output logic [PRIME_W-1:0] rdata_o
);

  logic [PRIME_W-1:0] mem_q [TABLE_DEPTH];
  logic [PRIME_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/spf_div.sv
module spf_div
  import spf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(VALUE_W);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [VALUE_W-1:0] rem_q, rem_d;
  logic [VALUE_W-1:0] quo_q, quo_d;
  logic [VALUE_W-1:0] den_q, den_d;
  logic [VALUE_W:0]   trial;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    trial  = {rem_q, quo_q[VALUE_W-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.num;
      den_d  = req_i.den;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = VALUE_W'(trial - {1'b0, den_q});
        quo_d = {quo_q[VALUE_W-2:0], 1'b1};
      end else begin
        rem_d = trial[VALUE_W-1:0];
        quo_d = {quo_q[VALUE_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(VALUE_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

FILE: design/spf_seq.sv
module spf_seq
  import spf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               opcode_i,
  input  logic [VALUE_W-1:0] value_i,
  input  logic               cfg_we_i,
  input  logic [IDX_W-1:0]   eff_lim_i,
  input  logic               out_ready_i,
  output res_t               res_o,
  output ram_req_t           ram_o,
  input  logic [PRIME_W-1:0] ram_rdata_i,
  output div_req_t           div_o,
  input  div_rsp_t           div_i
);

  seq_state_e         state_q, state_d;
  logic               built_q, built_d;
  logic [IDX_W-1:0]   lim_q, lim_d;
  logic [IDX_W-1:0]   i_q, i_d;
  logic [IDX_W-1:0]   j_q, j_d;
  logic [2*IDX_W-1:0] sq_q, sq_d;
  logic [VALUE_W-1:0] n_q, n_d;
  logic [PRIME_W-1:0] p_q, p_d;
  logic [EXP_W-1:0]   e_q, e_d;
  logic [K_W-1:0]     k_q, k_d;
  status_e            resp_q, resp_d;
  logic [IDX_W:0]     j_next;
  logic               i_done;
  logic               fact_last;
  logic               accept;

  assign in_stall_o = (state_q != SQ_IDLE);
  assign accept     = in_valid_i && (state_q == SQ_IDLE);
  assign j_next     = {1'b0, j_q} + {1'b0, i_q};
  assign i_done     = (i_q == lim_q);
  assign fact_last  = (n_q <= VALUE_W'(1)) || (k_q == K_W'(MAX_PRIMES - 1));

  always_comb begin
    state_d = state_q;
    built_d = built_q;
    lim_d   = lim_q;
    i_d     = i_q;
    j_d     = j_q;
    sq_d    = sq_q;
    n_d     = n_q;
    p_d     = p_q;
    e_d     = e_q;
    k_d     = k_q;
    resp_d  = resp_q;
    ram_o   = '0;
    div_o   = '0;
    res_o   = '0;
    res_o.status = ST_FACTOR;

    case (state_q)
      SQ_IDLE: begin
        if (accept) begin
          if (opcode_e'(opcode_i) == OP_BUILD) begin
            built_d = 1'b0;
            lim_d   = eff_lim_i;
            j_d     = '0;
            state_d = SQ_CLEAR;
          end else begin
            n_d = value_i;
            k_d = '0;
            if (!built_q) begin
              resp_d  = ST_NOTBUILT;
              state_d = SQ_RESP;
            end else if (value_i < VALUE_W'(2)) begin
              resp_d  = ST_NOFACT;
              state_d = SQ_RESP;
            end else if (32'(value_i) > 32'(lim_q)) begin
              resp_d  = ST_RANGE;
              state_d = SQ_RESP;
            end else begin
              state_d = SQ_FRD;
            end
          end
        end
      end
      SQ_CLEAR: begin
        ram_o.wr_en   = 1'b1;
        ram_o.wr_addr = j_q;
        if (j_q == lim_q) begin
          if (lim_q < IDX_W'(2)) begin
            built_d = 1'b1;
            resp_d  = ST_BUILT;
            state_d = SQ_RESP;
          end else begin
            i_d     = IDX_W'(2);
            state_d = SQ_SRD;
          end
        end else begin
          j_d = j_q + IDX_W'(1);
        end
      end
      SQ_SRD: begin
        ram_o.rd_en   = 1'b1;
        ram_o.rd_addr = i_q;
        sq_d          = {{IDX_W{1'b0}}, i_q} * {{IDX_W{1'b0}}, i_q};
        state_d       = SQ_SCHK;
      end
      SQ_SCHK: begin
        if (ram_rdata_i == '0) begin
          // An untouched entry is a prime: it is its own smallest factor.
          ram_o.wr_en   = 1'b1;
          ram_o.wr_addr = i_q;
          ram_o.wr_data = PRIME_W'(i_q);
        end
        if ((ram_rdata_i == '0) && (sq_q <= {{IDX_W{1'b0}}, lim_q})) begin
          j_d     = sq_q[IDX_W-1:0];
          state_d = SQ_MRD;
        end else if (i_done) begin
          built_d = 1'b1;
          resp_d  = ST_BUILT;
          state_d = SQ_RESP;
        end else begin
          i_d     = i_q + IDX_W'(1);
          state_d = SQ_SRD;
        end
      end
      SQ_MRD: begin
        ram_o.rd_en   = 1'b1;
        ram_o.rd_addr = j_q;
        state_d       = SQ_MCHK;
      end
      SQ_MCHK: begin
        if (ram_rdata_i == '0) begin
          ram_o.wr_en   = 1'b1;
          ram_o.wr_addr = j_q;
          ram_o.wr_data = PRIME_W'(i_q);
        end
        if (j_next <= {1'b0, lim_q}) begin
          j_d     = j_next[IDX_W-1:0];
          state_d = SQ_MRD;
        end else if (i_done) begin
          built_d = 1'b1;
          resp_d  = ST_BUILT;
          state_d = SQ_RESP;
        end else begin
          i_d     = i_q + IDX_W'(1);
          state_d = SQ_SRD;
        end
      end
      SQ_FRD: begin
        ram_o.rd_en   = 1'b1;
        ram_o.rd_addr = IDX_W'(n_q);
        state_d       = SQ_FCHK;
      end
      SQ_FCHK: begin
        if (ram_rdata_i < PRIME_W'(2)) begin
          p_d = PRIME_W'(n_q);
        end else begin
          p_d = ram_rdata_i;
        end
        e_d       = '0;
        div_o.start = 1'b1;
        div_o.num = n_q;
        div_o.den = VALUE_W'(p_d);
        state_d   = SQ_FDIV;
      end
      SQ_FDIV: begin
        if (div_i.done) begin
          if (div_i.rem == '0) begin
            n_d         = div_i.quot;
            e_d         = e_q + EXP_W'(1);
            div_o.start = 1'b1;
            div_o.num   = div_i.quot;
            div_o.den   = VALUE_W'(p_q);
          end else begin
            state_d = SQ_FEMIT;
          end
        end
      end
      SQ_FEMIT: begin
        if (out_ready_i) begin
          res_o.valid    = 1'b1;
          res_o.status   = ST_FACTOR;
          res_o.prime    = p_q;
          res_o.exponent = e_q;
          res_o.last     = fact_last;
          k_d            = k_q + K_W'(1);
          state_d        = fact_last ? SQ_IDLE : SQ_FRD;
        end
      end
      SQ_RESP: begin
        if (out_ready_i) begin
          res_o.valid  = 1'b1;
          res_o.status = resp_q;
          res_o.last   = 1'b1;
          state_d      = SQ_IDLE;
        end
      end
      default: begin
        state_d = SQ_IDLE;
      end
    endcase

    // A limit write invalidates the table.
    if (cfg_we_i) begin
      built_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
      built_q <= 1'b0;
      lim_q   <= '0;
    end else begin
      state_q <= state_d;
      built_q <= built_d;
      lim_q   <= lim_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    j_q    <= j_d;
    sq_q   <= sq_d;
    n_q    <= n_d;
    p_q    <= p_d;
    e_q    <= e_d;
    k_q    <= k_d;
    resp_q <= resp_d;
  end

  a_emit_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> out_ready_i)
    else $error("result emitted while the output register is busy");

  a_div_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_o.start |-> (div_o.den >= VALUE_W'(2)))
    else $error("division started with a divisor below two");

  a_prime_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (state_q == SQ_FEMIT)) |-> (p_q >= PRIME_W'(2)))
    else $error("factor result carries a prime below two");

  a_wr_build: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_o.wr_en |-> ((state_q == SQ_CLEAR) || (state_q == SQ_SCHK) ||
                     (state_q == SQ_MCHK)))
    else $error("table written outside a build");

endmodule
